/* sv/ecp_pkg.sv */
package ecp_pkg;

  localparam int unsigned COUNT_W = 9;
  localparam logic [COUNT_W-1:0] NARROW_LIMIT = 9'd16;

  localparam logic [1:0] OP_COLLECT = 2'd0;
  localparam logic [1:0] OP_INDEX   = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_ENTRY  = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_OVERFLOW = 2'd1;
  localparam logic [1:0] STAT_MISS     = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       first_pixel;
    logic       last_pixel;
    logic [7:0] entry_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         data_byte;
    logic [31:0]        palette_color;
    logic [COUNT_W-1:0] color_count;
    logic               wide_mode;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic done;
    logic hit;
  } srch_res_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_EMIT   = 3'b100
  } ctrl_state_e;

endpackage

/* sv/ecp_ram.sv */
module ecp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/ecp_search.sv */
module ecp_search import ecp_pkg::*; #(
  parameter int unsigned AW = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [31:0]        color_i,
  input  logic [COUNT_W-1:0] count_i,
  input  logic [31:0]        rdata_i,
  output logic               rd_en_o,
  output logic [AW-1:0]      rd_addr_o,
  output srch_res_t          res_o,
  output logic [AW-1:0]      idx_o
);

  logic               busy_q;
  logic [COUNT_W-1:0] pos_q;
  logic               chk_q;
  logic [AW-1:0]      chk_idx_q;
  logic               more;
  logic               hit;
  logic               issue;
  logic               done;

  // one table entry read per cycle, compared in the cycle after its read
  assign more  = pos_q < count_i;
  assign hit   = chk_q && (rdata_i == color_i);
  assign issue = busy_q && more && !hit;
  assign done  = busy_q && (hit || (!chk_q && !more));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= '0;
      chk_q  <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      pos_q  <= '0;
      chk_q  <= 1'b0;
    end else if (busy_q) begin
      if (done) begin
        busy_q <= 1'b0;
      end
      chk_q <= issue;
      if (issue) begin
        pos_q <= pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      chk_idx_q <= pos_q[AW-1:0];
    end
  end

  assign rd_en_o   = issue;
  assign rd_addr_o = pos_q[AW-1:0];
  assign res_o     = '{done: done, hit: hit};
  assign idx_o     = chk_idx_q;

endmodule

/* sv/exact_color_palettizer_core.sv */
// Exact palette builder and index encoder. A collect or index item scans the
// colour table one entry per cycle through the single read port of the table
// RAM and one 32-bit comparator, up to the fill count of the table; a palette
// read item reads the addressed entry directly. The table needs no clearing
// pass: the fill count bounds every search and readback. A finished result
// sits in an output register, and the next item is taken while it waits.
module exact_color_palettizer_core import ecp_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned AW = $clog2(PALETTE_DEPTH);
  localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(PALETTE_DEPTH);

  ctrl_state_e        state_q, state_d;
  logic               alpha_en_q;
  logic [COUNT_W-1:0] count_q;
  logic               ovf_q;
  logic               parity_q;
  logic [3:0]         pend_q;
  logic               pmiss_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic [1:0]         op_q;
  logic               last_q;
  logic               rb_ok_q;
  logic [31:0]        color_q;
  logic               hit_q;
  logic [AW-1:0]      idx_q;

  logic               accept;
  logic [31:0]        color_in;
  logic               rb_en;
  logic               srch_rd_en;
  logic [AW-1:0]      srch_rd_addr;
  srch_res_t          srch_res;
  logic [AW-1:0]      srch_idx;
  logic [31:0]        rdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;

  logic               out_free;
  logic               has_res;
  logic               emit_go;
  out_item_t          res;
  logic               wr_en;
  logic [COUNT_W-1:0] count_d;
  logic               ovf_d;
  logic               parity_d;
  logic [3:0]         pend_d;
  logic               pmiss_d;
  logic [COUNT_W-1:0] total;
  logic [7:0]         idx8;
  logic               miss;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign color_in   = {alpha_en_q ? in_data_i.alpha : 8'hFF, in_data_i.blue,
                       in_data_i.green, in_data_i.red};
  assign rb_en      = accept && (in_data_i.op == OP_READ);

  assign ram_re    = srch_rd_en || rb_en;
  assign ram_raddr = rb_en ? in_data_i.entry_index[AW-1:0] : srch_rd_addr;

  ecp_ram #(
    .WIDTH(32),
    .DEPTH(PALETTE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i(color_q),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(rdata)
  );

  ecp_search #(
    .AW(AW)
  ) u_search (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept && (in_data_i.op == OP_COLLECT || in_data_i.op == OP_INDEX)),
    .color_i  (color_q),
    .count_i  (count_q),
    .rdata_i  (rdata),
    .rd_en_o  (srch_rd_en),
    .rd_addr_o(srch_rd_addr),
    .res_o    (srch_res),
    .idx_o    (srch_idx)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign miss     = !hit_q;
  assign idx8     = hit_q ? 8'(idx_q) : 8'd0;

  always_comb begin
    has_res  = 1'b0;
    res      = '0;
    wr_en    = 1'b0;
    count_d  = count_q;
    ovf_d    = ovf_q;
    parity_d = parity_q;
    pend_d   = pend_q;
    pmiss_d  = pmiss_q;
    total    = '0;
    emit_go  = 1'b0;
    if (state_q == S_EMIT) begin
      case (op_q)
        OP_COLLECT: begin
          if (!hit_q) begin
            if (count_q < DEPTH_C) begin
              wr_en   = 1'b1;
              count_d = count_q + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
          end
          total             = count_d + COUNT_W'(ovf_d);
          has_res           = last_q;
          res.kind          = KIND_STATUS;
          res.color_count   = total;
          res.wide_mode     = total > NARROW_LIMIT;
          res.status        = ovf_d ? STAT_OVERFLOW : STAT_OK;
        end
        OP_INDEX: begin
          res.kind = KIND_BYTE;
          if (count_q > NARROW_LIMIT) begin
            has_res        = 1'b1;
            res.data_byte  = idx8;
            res.status     = miss ? STAT_MISS : STAT_OK;
          end else if (!parity_q) begin
            if (!last_q) begin
              parity_d = 1'b1;
              pend_d   = idx8[3:0];
              pmiss_d  = miss;
            end else begin
              has_res       = 1'b1;
              res.data_byte = {4'h0, idx8[3:0]};
              res.status    = miss ? STAT_MISS : STAT_OK;
              pend_d        = 4'h0;
              pmiss_d       = 1'b0;
            end
          end else begin
            has_res       = 1'b1;
            res.data_byte = {idx8[3:0], pend_q};
            res.status    = (pmiss_q || miss) ? STAT_MISS : STAT_OK;
            parity_d      = 1'b0;
            pend_d        = 4'h0;
            pmiss_d       = 1'b0;
          end
        end
        OP_READ: begin
          has_res           = 1'b1;
          res.kind          = KIND_ENTRY;
          res.palette_color = rb_ok_q ? rdata : 32'd0;
        end
        default: begin
          has_res = 1'b0;
        end
      endcase
      emit_go = !has_res || out_free;
      if (!emit_go) begin
        wr_en = 1'b0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_data_i.op == OP_COLLECT || in_data_i.op == OP_INDEX) begin
            state_d = S_SEARCH;
          end else if (in_data_i.op == OP_READ) begin
            state_d = S_EMIT;
          end
        end
      end
      S_SEARCH: begin
        if (srch_res.done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      alpha_en_q  <= 1'b0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      parity_q    <= 1'b0;
      pend_q      <= 4'h0;
      pmiss_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        alpha_en_q <= cfg_wdata_i;
      end
      if (accept && in_data_i.first_pixel) begin
        if (in_data_i.op == OP_COLLECT) begin
          count_q <= '0;
          ovf_q   <= 1'b0;
        end else if (in_data_i.op == OP_INDEX) begin
          parity_q <= 1'b0;
          pend_q   <= 4'h0;
          pmiss_q  <= 1'b0;
        end
      end
      if (emit_go) begin
        count_q  <= count_d;
        ovf_q    <= ovf_d;
        parity_q <= parity_d;
        pend_q   <= pend_d;
        pmiss_q  <= pmiss_d;
      end
      if (emit_go && has_res) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= in_data_i.op;
      last_q  <= in_data_i.last_pixel;
      color_q <= color_in;
      rb_ok_q <= {1'b0, in_data_i.entry_index} < count_q;
    end
    if (state_q == S_SEARCH && srch_res.done) begin
      hit_q <= srch_res.hit;
      idx_q <= srch_idx;
    end
    if (emit_go && has_res) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("entry count beyond table depth");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> count_q == DEPTH_C)
    else $error("overflow flagged with room left in table");

  a_done_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    srch_res.done |-> state_q == S_SEARCH)
    else $error("search finished outside search state");

  a_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (count_q < DEPTH_C) && !hit_q && (op_q == OP_COLLECT))
    else $error("table write without room or for a known colour");

endmodule

/* tb/sv/testbench.sv */
module testbench;
  import ecp_pkg::*;

  localparam int unsigned DEPTH = 256;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 750;
  localparam int BIG_PHASE = 6;
  localparam int HOLD_PHASE = 4;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 300;
  localparam int DRAIN_LIMIT = 60000;

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t want;
  } script_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_we_i;
  logic      cfg_wdata_i;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  exact_color_palettizer_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // palette shadow state
  logic [31:0] pal_q [DEPTH];
  int unsigned pal_cnt;
  bit          pal_ovf;
  bit          nib_odd;
  logic [3:0]  nib_val;
  bit          nib_miss;
  bit          alpha_keep;

  out_item_t   expected_q [$];
  script_row_t script_q [$];
  logic [31:0] pool_q [$];
  int          fault_count;
  int          items_sent;
  bit          sender_burst;
  bit          hold_req;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #12_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [31:0] pixel_color(input in_item_t it);
    return {alpha_keep ? it.alpha : 8'hFF, it.blue, it.green, it.red};
  endfunction

  function automatic int unsigned find_entry(input logic [31:0] c);
    int unsigned i;
    for (i = 0; i < pal_cnt; i++)
      if (pal_q[i] == c) return i;
    return DEPTH;
  endfunction

  function automatic bit predict_palette(input in_item_t it, output out_item_t res);
    logic [31:0] c;
    int unsigned pos;
    int unsigned total;
    bit miss;
    logic [7:0] ix;
    res = '0;
    case (it.op)
      OP_COLLECT: begin
        if (it.first_pixel) begin
          pal_cnt = 0;
          pal_ovf = 1'b0;
        end
        c = pixel_color(it);
        if (find_entry(c) == DEPTH) begin
          if (pal_cnt < DEPTH) begin
            pal_q[pal_cnt] = c;
            pal_cnt++;
          end else begin
            pal_ovf = 1'b1;
          end
        end
        if (!it.last_pixel) return 1'b0;
        total = pal_cnt + (pal_ovf ? 1 : 0);
        res.kind = KIND_STATUS;
        res.color_count = total[COUNT_W-1:0];
        res.wide_mode = (total > NARROW_LIMIT);
        res.status = pal_ovf ? STAT_OVERFLOW : STAT_OK;
        return 1'b1;
      end
      OP_INDEX: begin
        pos = find_entry(pixel_color(it));
        miss = (pos == DEPTH);
        ix = miss ? 8'd0 : pos[7:0];
        if (it.first_pixel) begin
          nib_odd = 1'b0;
          nib_val = '0;
          nib_miss = 1'b0;
        end
        res.kind = KIND_BYTE;
        if (pal_cnt > NARROW_LIMIT) begin
          res.data_byte = ix;
          res.status = miss ? STAT_MISS : STAT_OK;
          return 1'b1;
        end
        if (!nib_odd) begin
          nib_val = ix[3:0];
          nib_miss = miss;
          if (!it.last_pixel) begin
            nib_odd = 1'b1;
            return 1'b0;
          end
          res.data_byte = {4'h0, nib_val};
          res.status = nib_miss ? STAT_MISS : STAT_OK;
        end else begin
          res.data_byte = {ix[3:0], nib_val};
          res.status = (nib_miss || miss) ? STAT_MISS : STAT_OK;
        end
        nib_odd = 1'b0;
        nib_val = '0;
        nib_miss = 1'b0;
        return 1'b1;
      end
      OP_READ: begin
        res.kind = KIND_ENTRY;
        res.palette_color = (it.entry_index < pal_cnt) ? pal_q[it.entry_index] : '0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic in_item_t make_pixel(input logic [1:0] op, input logic [31:0] c,
                                          input bit first, input bit last,
                                          input logic [7:0] entry);
    in_item_t p;
    p.op = op;
    p.red = c[7:0];
    p.green = c[15:8];
    p.blue = c[23:16];
    p.alpha = c[31:24];
    p.first_pixel = first;
    p.last_pixel = last;
    p.entry_index = entry;
    return p;
  endfunction

  function automatic out_item_t make_result(input logic [1:0] kind, input logic [7:0] data,
                                            input logic [31:0] color,
                                            input logic [COUNT_W-1:0] count,
                                            input bit wide, input logic [1:0] status);
    out_item_t r;
    r.kind = kind;
    r.data_byte = data;
    r.palette_color = color;
    r.color_count = count;
    r.wide_mode = wide;
    r.status = status;
    return r;
  endfunction

  function automatic void add_row(input in_item_t it, input bit typed = 1'b0,
                                  input out_item_t want = '0);
    script_row_t row;
    row.it = it;
    row.typed = typed;
    row.want = want;
    script_q.push_back(row);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fault_count++;
    end
  endfunction

  task automatic send_item(input in_item_t it, input bit typed = 1'b0,
                           input out_item_t want = '0);
    int gap;
    out_item_t pred;
    gap = sender_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i = it;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (predict_palette(it, pred)) expected_q.push_back(typed ? want : pred);
    if (it.op != OP_UNUSED) items_sent++;
    @(negedge clk_i);
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    in_valid_i = 1'b0;
    while (expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_alpha_keep(input bit v);
    cfg_wdata_i = v;
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    alpha_keep = v;
  endtask

  task automatic run_collect(input int k, input int extra, input bit distinct,
                             input bit tidy);
    int n;
    int nxt;
    int i;
    logic [31:0] c;
    bit clear;
    bit close;
    pool_q.delete();
    for (i = 0; i < k; i++) begin
      c = $urandom;
      if (distinct) begin
        c[7:0] = i[7:0];
        c[16] = i[8];
      end
      pool_q.push_back(c);
    end
    clear = tidy || ($urandom_range(0, 9) != 0);
    close = tidy || ($urandom_range(0, 9) != 0);
    n = k + extra;
    nxt = 0;
    for (i = 0; i < n; i++) begin
      if (nxt == 0 || (nxt < k && $urandom_range(1, n - i) <= k - nxt)) begin
        c = pool_q[nxt];
        nxt++;
      end else begin
        c = pool_q[$urandom_range(0, nxt - 1)];
        if (!alpha_keep) c[31:24] = 8'($urandom);
      end
      send_item(make_pixel(OP_COLLECT, c, clear && i == 0, close && i == n - 1,
                           8'($urandom)));
    end
  endtask

  task automatic run_reads(input int n);
    int lim;
    logic [7:0] e;
    lim = (pool_q.size() + 2 > 255) ? 255 : pool_q.size() + 2;
    repeat (n) begin
      if ($urandom_range(0, 4) == 0) e = 8'($urandom_range(0, 255));
      else e = 8'($urandom_range(0, lim));
      send_item(make_pixel(OP_READ, $urandom, 1'($urandom), 1'($urandom), e));
    end
  endtask

  task automatic run_index(input int n);
    int i;
    logic [31:0] c;
    bit fresh;
    bit clean;
    fresh = ($urandom_range(0, 7) != 0);
    clean = ($urandom_range(0, 7) != 0);
    for (i = 0; i < n; i++) begin
      if (pool_q.size() != 0 && $urandom_range(0, 9) != 0) begin
        c = pool_q[$urandom_range(0, pool_q.size() - 1)];
        if (!alpha_keep) c[31:24] = 8'($urandom);
      end else begin
        c = $urandom;
      end
      send_item(make_pixel(OP_INDEX, c,
                           (fresh && i == 0) || ($urandom_range(0, 29) == 0),
                           (clean && i == n - 1) || ($urandom_range(0, 29) == 0),
                           8'($urandom)));
    end
  endtask

  // result checker
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $error("item with no result waiting: kind %0d", out_data_o.kind);
        fault_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("kind", want.kind, out_data_o.kind);
        check_field("data_byte", want.data_byte, out_data_o.data_byte);
        check_field("palette_color", want.palette_color, out_data_o.palette_color);
        check_field("color_count", want.color_count, out_data_o.color_count);
        check_field("wide_mode", want.wide_mode, out_data_o.wide_mode);
        check_field("status", want.status, out_data_o.status);
      end
    end
  end

  // receiver
  initial begin : receiver
    int stall;
    int served;
    bit rx_burst;
    out_ready_i = 1'b0;
    served = 0;
    rx_burst = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (served % 32 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      if (hold_req) begin
        stall = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall = rx_burst ? 0 : $urandom_range(0, 19);
      end
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      served++;
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    int phase;
    int k;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    fault_count = 0;
    items_sent = 0;
    sender_burst = 1'b0;
    hold_req = 1'b0;
    pal_cnt = 0;
    pal_ovf = 1'b0;
    nib_odd = 1'b0;
    nib_val = '0;
    nib_miss = 1'b0;
    alpha_keep = 1'b0;
    foreach (pal_q[i]) pal_q[i] = '0;

    // empty table, forced alpha, dedup, nibble packing and parity handling
    add_row(make_pixel(OP_READ, 32'h0, 1'b0, 1'b0, 8'd0), 1'b1,
            make_result(KIND_ENTRY, 8'd0, 32'h0, 9'd0, 1'b0, STAT_OK));
    add_row(make_pixel(OP_READ, 32'hFFFFFFFF, 1'b1, 1'b1, 8'd255), 1'b1,
            make_result(KIND_ENTRY, 8'd0, 32'h0, 9'd0, 1'b0, STAT_OK));
    add_row(make_pixel(OP_INDEX, 32'h0, 1'b1, 1'b1, 8'd0), 1'b1,
            make_result(KIND_BYTE, 8'd0, 32'h0, 9'd0, 1'b0, STAT_MISS));
    add_row(make_pixel(OP_UNUSED, 32'hFFFFFFFF, 1'b1, 1'b1, 8'hFF));
    add_row(make_pixel(OP_COLLECT, 32'h00000000, 1'b1, 1'b0, 8'd0));
    add_row(make_pixel(OP_COLLECT, 32'hFFFFFFFF, 1'b0, 1'b0, 8'd0));
    add_row(make_pixel(OP_COLLECT, 32'h12000000, 1'b0, 1'b0, 8'd0));
    add_row(make_pixel(OP_COLLECT, 32'h7F563412, 1'b0, 1'b1, 8'd0), 1'b1,
            make_result(KIND_STATUS, 8'd0, 32'h0, 9'd3, 1'b0, STAT_OK));
    add_row(make_pixel(OP_READ, 32'h0, 1'b0, 1'b0, 8'd0));
    add_row(make_pixel(OP_READ, 32'h0, 1'b0, 1'b0, 8'd2));
    add_row(make_pixel(OP_READ, 32'h0, 1'b0, 1'b0, 8'd3), 1'b1,
            make_result(KIND_ENTRY, 8'd0, 32'h0, 9'd0, 1'b0, STAT_OK));
    add_row(make_pixel(OP_INDEX, 32'hFFFFFFFF, 1'b1, 1'b0, 8'd0));
    add_row(make_pixel(OP_INDEX, 32'h00563412, 1'b0, 1'b0, 8'd0));
    add_row(make_pixel(OP_INDEX, 32'h00000000, 1'b0, 1'b0, 8'd0));
    add_row(make_pixel(OP_INDEX, 32'h80030201, 1'b0, 1'b1, 8'd0));
    add_row(make_pixel(OP_INDEX, 32'h7F563412, 1'b1, 1'b1, 8'd0));
    add_row(make_pixel(OP_INDEX, 32'hFFFFFFFF, 1'b1, 1'b0, 8'd0));
    add_row(make_pixel(OP_INDEX, 32'h7F563412, 1'b1, 1'b1, 8'd0));
    add_row(make_pixel(OP_INDEX, 32'hFFFFFFFF, 1'b0, 1'b0, 8'd0));
    add_row(make_pixel(OP_READ, 32'h0, 1'b0, 1'b0, 8'd1));
    add_row(make_pixel(OP_INDEX, 32'h80030201, 1'b0, 1'b1, 8'd0));
    add_row(make_pixel(OP_COLLECT, 32'h0, 1'b1, 1'b1, 8'hFF), 1'b1,
            make_result(KIND_STATUS, 8'd0, 32'h0, 9'd1, 1'b0, STAT_OK));
    add_row(make_pixel(OP_INDEX, 32'hFFFFFFFF, 1'b1, 1'b1, 8'd0));

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (script_q[i]) send_item(script_q[i].it, script_q[i].typed, script_q[i].want);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      phase++;
      settle();
      if (phase == 1) set_alpha_keep(1'b1);
      else if (phase == 2) set_alpha_keep(1'b0);
      else if ($urandom_range(0, 2) == 0) set_alpha_keep(1'($urandom_range(0, 1)));
      sender_burst = ($urandom_range(0, 3) == 0);
      // 16 and 17 colours sit either side of the nibble mode limit
      if (phase == BIG_PHASE) k = DEPTH + 2;
      else if (phase == 1) k = 16;
      else if (phase == 2) k = 17;
      else k = $urandom_range(1, 24);
      run_collect(k, $urandom_range(0, 6), phase == BIG_PHASE,
                  phase <= 2 || phase == BIG_PHASE);
      run_reads($urandom_range(1, 4));
      run_index(phase == BIG_PHASE ? 24 : $urandom_range(1, 20));
      if (phase == HOLD_PHASE) begin
        // receiver stalls while items keep coming
        hold_req = 1'b1;
        sender_burst = 1'b1;
        run_reads(30);
        run_index(10);
      end
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3))
          send_item(make_pixel(2'($urandom_range(0, 3)), $urandom, 1'($urandom),
                               1'($urandom), 8'($urandom)));
      end
    end

    settle();
    if (expected_q.size() != 0) begin
      $error("%0d results never arrived", expected_q.size());
      fault_count++;
    end
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
